/* rtl/core/altc_pkg.sv */
// Shared types and constants of the access-log to TSV converter.
// Depends on nothing; used by the parser, command queue, emitter and top level.
`timescale 1ns / 1ps
`default_nettype none
package altc_pkg;

  localparam int MAX_LINE_DEF = 4096;
  localparam int CQ_DEPTH     = 4;
  localparam int CQ_AW        = 2;

  localparam logic [1:0] ERR_LAYOUT = 2'd0;
  localparam logic [1:0] ERR_LONG   = 2'd1;
  localparam logic [1:0] ERR_DATE   = 2'd2;
  localparam logic [1:0] ERR_MONTH  = 2'd3;

  localparam logic [4:0] STAMP_LAST = 5'd24;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_ERR,
    CMD_STAMP
  } cmd_kind_t;

  // Timestamp fields: year, day, time and offset held as BCD digits, the month as an index from 0 to 11.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  mon;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  min;
    logic [7:0]  sec;
    logic        neg;
    logic [15:0] off;
  } stamp_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [1:0] code;
    stamp_t     stamp;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cq_stat_t;

  function automatic logic [23:0] month_name(input logic [3:0] idx);
    logic [23:0] n;
    unique case (idx)
      4'd0:    n = "Jan";
      4'd1:    n = "Feb";
      4'd2:    n = "Mar";
      4'd3:    n = "Apr";
      4'd4:    n = "May";
      4'd5:    n = "Jun";
      4'd6:    n = "Jul";
      4'd7:    n = "Aug";
      4'd8:    n = "Sep";
      4'd9:    n = "Oct";
      4'd10:   n = "Nov";
      4'd11:   n = "Dec";
      default: n = 24'h0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/altc_front.sv */
// Front end: parses log bytes and issues one command per byte at most.
// Depends on altc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module altc_front #(
  parameter int MAX_LINE = altc_pkg::MAX_LINE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    byte_in,
  output altc_pkg::cmd_t     cmd,
  output logic               cmd_push
);
  import altc_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE);

  typedef enum logic [4:0] {
    PH_START, PH_HOST, PH_GAP_IDENT, PH_IDENT, PH_GAP_USER, PH_USER,
    PH_GAP_TIME, PH_DAY, PH_MON, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC,
    PH_OFF_LEAD, PH_OFF_DIG, PH_GAP_REQ, PH_REQ, PH_GAP_STATUS, PH_STATUS,
    PH_GAP_BYTES, PH_BYTES, PH_GAP_REF, PH_REF, PH_GAP_AGENT, PH_AGENT, PH_EOL
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [2:0]         dc_r, dc_nxt;
  stamp_t             st_r, st_nxt;
  logic [7:0]         mc0_r, mc0_nxt, mc1_r, mc1_nxt;
  logic               mbad_r, mbad_nxt;
  logic               halted_r, halted_nxt;

  logic               em, fl, bu;
  logic [7:0]         em_b;
  logic [1:0]         fl_c;
  logic               blank, digit, nl, nul;
  logic [3:0]         d;
  logic               m_hit;
  logic [3:0]         m_idx;

  assign blank = (byte_in == 8'h20) || (byte_in == 8'h09) || (byte_in == 8'h0B) ||
                 (byte_in == 8'h0C) || (byte_in == 8'h0D);
  assign digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
  assign nl    = (byte_in == 8'h0A);
  assign nul   = (byte_in == 8'h00);
  assign d     = byte_in[3:0];

  always_comb begin
    m_hit = 1'b0;
    m_idx = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (month_name(4'(i)) == {mc0_r, mc1_r, byte_in}) begin
        m_hit = 1'b1;
        m_idx = 4'(i);
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    dc_nxt     = dc_r;
    st_nxt     = st_r;
    mc0_nxt    = mc0_r;
    mc1_nxt    = mc1_r;
    mbad_nxt   = mbad_r;
    halted_nxt = halted_r;
    em = 1'b0; em_b = 8'h00; fl = 1'b0; fl_c = ERR_LAYOUT; bu = 1'b0;

    if (take && !halted_r) begin
      if (!nl && (len_r >= LEN_W'(MAX_LINE - 2))) begin
        fl = 1'b1; fl_c = ERR_LONG;
      end else begin
        len_nxt = nl ? '0 : len_r + 1'b1;
        unique case (phase_r)
          PH_START: begin
            if (nl) begin
              em = 1'b1; em_b = 8'h0A;
            end else if (nul) begin
              fl = 1'b1;
            end else if (blank) begin
              em = 1'b1; em_b = 8'h09; phase_nxt = PH_GAP_IDENT;
            end else begin
              em = 1'b1; em_b = byte_in; phase_nxt = PH_HOST;
            end
          end
          PH_HOST, PH_IDENT, PH_USER, PH_STATUS, PH_BYTES: begin
            if (nl || nul) fl = 1'b1;
            else if (blank) begin
              em = 1'b1; em_b = 8'h09;
              unique case (phase_r)
                PH_HOST:   phase_nxt = PH_GAP_IDENT;
                PH_IDENT:  phase_nxt = PH_GAP_USER;
                PH_USER:   phase_nxt = PH_GAP_TIME;
                PH_STATUS: phase_nxt = PH_GAP_BYTES;
                default:   phase_nxt = PH_GAP_REF;
              endcase
            end else begin
              em = 1'b1; em_b = byte_in;
            end
          end
          PH_GAP_IDENT, PH_GAP_USER, PH_GAP_STATUS, PH_GAP_BYTES: begin
            if (nl || nul) fl = 1'b1;
            else if (!blank) begin
              em = 1'b1; em_b = byte_in;
              unique case (phase_r)
                PH_GAP_IDENT:  phase_nxt = PH_IDENT;
                PH_GAP_USER:   phase_nxt = PH_USER;
                PH_GAP_STATUS: phase_nxt = PH_STATUS;
                default:       phase_nxt = PH_BYTES;
              endcase
            end
          end
          PH_GAP_TIME: begin
            if (byte_in == "[") begin
              st_nxt = '0; dc_nxt = '0; mc0_nxt = '0; mc1_nxt = '0;
              mbad_nxt = 1'b0; phase_nxt = PH_DAY;
            end else if (!blank) fl = 1'b1;
          end
          PH_DAY, PH_HOUR, PH_MIN: begin
            if (digit && dc_r < 3'd2) begin
              dc_nxt = dc_r + 1'b1;
              unique case (phase_r)
                PH_DAY:  st_nxt.day  = {st_r.day[3:0], d};
                PH_HOUR: st_nxt.hour = {st_r.hour[3:0], d};
                default: st_nxt.min  = {st_r.min[3:0], d};
              endcase
            end else if (byte_in == ((phase_r == PH_DAY) ? 8'h2F : 8'h3A) &&
                         dc_r >= 3'd1) begin
              dc_nxt = '0;
              unique case (phase_r)
                PH_DAY:  phase_nxt = PH_MON;
                PH_HOUR: phase_nxt = PH_MIN;
                default: phase_nxt = PH_SEC;
              endcase
            end else begin
              fl = 1'b1; fl_c = ERR_DATE;
            end
          end
          PH_YEAR: begin
            if (digit && dc_r < 3'd4) begin
              dc_nxt = dc_r + 1'b1; st_nxt.year = {st_r.year[11:0], d};
            end else if (byte_in == ":" && dc_r >= 3'd4) begin
              dc_nxt = '0; phase_nxt = PH_HOUR;
            end else begin
              fl = 1'b1; fl_c = ERR_DATE;
            end
          end
          PH_MON: begin
            if (dc_r == 3'd0 && blank) begin
              // leading blanks before the month name are skipped
            end else if (dc_r < 3'd3 && !nul && !nl && !blank) begin
              dc_nxt = dc_r + 1'b1;
              if (dc_r == 3'd0) begin
                mc0_nxt = byte_in; mc1_nxt = 8'h00;
              end else if (dc_r == 3'd1) begin
                mc1_nxt = byte_in;
              end else begin
                mbad_nxt = !m_hit; st_nxt.mon = m_idx;
              end
            end else if (dc_r == 3'd3 && byte_in == "/") begin
              dc_nxt = '0; phase_nxt = PH_YEAR;
            end else begin
              fl = 1'b1; fl_c = ERR_DATE;
            end
          end
          PH_SEC, PH_OFF_LEAD: begin
            if (phase_r == PH_SEC && digit && dc_r < 3'd2) begin
              dc_nxt = dc_r + 1'b1; st_nxt.sec = {st_r.sec[3:0], d};
            end else if (phase_r == PH_SEC && dc_r == 3'd0) begin
              fl = 1'b1; fl_c = ERR_DATE;
            end else begin
              // end of the seconds falls straight into the offset lead-in
              dc_nxt = '0; phase_nxt = PH_OFF_LEAD;
              if (blank) begin
              end else if (byte_in == "+" || byte_in == "-") begin
                st_nxt.neg = (byte_in == "-"); phase_nxt = PH_OFF_DIG;
              end else if (digit) begin
                st_nxt.off = {12'h000, d}; dc_nxt = 3'd1; phase_nxt = PH_OFF_DIG;
              end else begin
                fl = 1'b1; fl_c = ERR_DATE;
              end
            end
          end
          PH_OFF_DIG: begin
            if (digit) begin
              if (dc_r < 3'd4) begin
                dc_nxt = dc_r + 1'b1; st_nxt.off = {st_r.off[11:0], d};
              end else begin
                fl = 1'b1; fl_c = ERR_DATE;
              end
            end else if (dc_r == 3'd0) begin
              fl = 1'b1; fl_c = ERR_DATE;
            end else if (mbad_r) begin
              fl = 1'b1; fl_c = ERR_MONTH;
            end else if (byte_in == "]") begin
              bu = 1'b1; dc_nxt = '0; phase_nxt = PH_GAP_REQ;
            end else fl = 1'b1;
          end
          PH_GAP_REQ, PH_GAP_REF, PH_GAP_AGENT: begin
            if (byte_in == 8'h22) begin
              unique case (phase_r)
                PH_GAP_REQ: phase_nxt = PH_REQ;
                PH_GAP_REF: phase_nxt = PH_REF;
                default:    phase_nxt = PH_AGENT;
              endcase
            end else if (!blank) fl = 1'b1;
          end
          PH_REQ, PH_REF, PH_AGENT: begin
            if (byte_in == 8'h22) begin
              // the agent's closing quote brings no tab
              em = (phase_r != PH_AGENT); em_b = 8'h09;
              unique case (phase_r)
                PH_REQ:  phase_nxt = PH_GAP_STATUS;
                PH_REF:  phase_nxt = PH_GAP_AGENT;
                default: phase_nxt = PH_EOL;
              endcase
            end else if (nl || nul) fl = 1'b1;
            else begin
              em = 1'b1; em_b = byte_in;
            end
          end
          PH_EOL: begin
            if (nl) begin
              em = 1'b1; em_b = 8'h0A; phase_nxt = PH_START;
            end else fl = 1'b1;
          end
          default: fl = 1'b1;
        endcase
      end
    end
    if (fl) halted_nxt = 1'b1;
  end

  always_comb begin
    cmd_push   = em || fl || bu;
    cmd.kind   = fl ? CMD_ERR : (bu ? CMD_STAMP : CMD_BYTE);
    cmd.data   = em_b;
    cmd.code   = fl_c;
    cmd.stamp  = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      len_r    <= '0;
      dc_r     <= '0;
      st_r     <= '0;
      mc0_r    <= '0;
      mc1_r    <= '0;
      mbad_r   <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      dc_r     <= dc_nxt;
      st_r     <= st_nxt;
      mc0_r    <= mc0_nxt;
      mc1_r    <= mc1_nxt;
      mbad_r   <= mbad_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/altc_cmd_queue.sv */
// Short command queue between parser and emitter.
// Depends on altc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module altc_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire altc_pkg::cmd_t din,
  input  wire logic          pop,
  output altc_pkg::cmd_t     dout,
  output altc_pkg::cq_stat_t stat
);
  import altc_pkg::*;

  cmd_t               mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CQ_AW:0]     cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (CQ_AW+1)'(do_push) - (CQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/altc_back.sv */
// Back end: expands commands into result bytes and holds the output register.
// Depends on altc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module altc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire altc_pkg::cmd_t cmd,
  input  wire logic          cmd_avail,
  output logic               cmd_pop,
  input  wire logic          res_pop,
  output logic               res_valid,
  output logic [7:0]         res_byte,
  output logic               res_err,
  output logic [1:0]         res_code,
  output logic               res_last
);
  import altc_pkg::*;

  logic [4:0] idx_r, idx_nxt;
  logic       val_r, val_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       err_r, err_nxt, last_r, last_nxt;
  logic [1:0] code_r, code_nxt;
  logic       adv, done;
  logic [7:0] sb, mon_bcd;
  stamp_t     s;

  function automatic logic [7:0] dig(input logic [3:0] n);
    return {4'h3, n};
  endfunction

  assign s       = cmd.stamp;
  assign mon_bcd = (s.mon >= 4'd9) ? {4'h1, s.mon - 4'd9} : {4'h0, s.mon + 4'd1};

  always_comb begin
    unique case (idx_r)
      5'd0:    sb = dig(s.year[15:12]);
      5'd1:    sb = dig(s.year[11:8]);
      5'd2:    sb = dig(s.year[7:4]);
      5'd3:    sb = dig(s.year[3:0]);
      5'd4:    sb = "-";
      5'd5:    sb = dig(mon_bcd[7:4]);
      5'd6:    sb = dig(mon_bcd[3:0]);
      5'd7:    sb = "-";
      5'd8:    sb = dig(s.day[7:4]);
      5'd9:    sb = dig(s.day[3:0]);
      5'd10:   sb = "T";
      5'd11:   sb = dig(s.hour[7:4]);
      5'd12:   sb = dig(s.hour[3:0]);
      5'd13:   sb = ":";
      5'd14:   sb = dig(s.min[7:4]);
      5'd15:   sb = dig(s.min[3:0]);
      5'd16:   sb = ":";
      5'd17:   sb = dig(s.sec[7:4]);
      5'd18:   sb = dig(s.sec[3:0]);
      5'd19:   sb = (s.neg && s.off != 16'h0) ? "-" : "+";
      5'd20:   sb = dig(s.off[15:12]);
      5'd21:   sb = dig(s.off[11:8]);
      5'd22:   sb = dig(s.off[7:4]);
      5'd23:   sb = dig(s.off[3:0]);
      default: sb = 8'h09;
    endcase
  end

  always_comb begin
    adv      = !val_r || res_pop;
    done     = (cmd.kind != CMD_STAMP) || (idx_r == STAMP_LAST);
    cmd_pop  = adv && cmd_avail && done;
    idx_nxt  = idx_r;
    val_nxt  = val_r;
    byte_nxt = byte_r;
    err_nxt  = err_r;
    code_nxt = code_r;
    last_nxt = last_r;
    if (adv) begin
      val_nxt = cmd_avail;
      if (cmd_avail) begin
        idx_nxt  = done ? 5'd0 : idx_r + 5'd1;
        last_nxt = done;
        err_nxt  = (cmd.kind == CMD_ERR);
        code_nxt = (cmd.kind == CMD_ERR) ? cmd.code : ERR_LAYOUT;
        unique case (cmd.kind)
          CMD_BYTE:  byte_nxt = cmd.data;
          CMD_STAMP: byte_nxt = sb;
          default:   byte_nxt = 8'h00;
        endcase
      end
    end
  end

  assign res_valid = val_r;
  assign res_byte  = byte_r;
  assign res_err   = err_r;
  assign res_code  = code_r;
  assign res_last  = last_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    err_r  <= err_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      idx_r <= '0;
      val_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      val_r <= val_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/access_log_to_tsv_converter.sv */
// Top level of the access-log to TSV converter: parser, command queue, emitter.
// Depends on altc_pkg, altc_front, altc_cmd_queue and altc_back.
//
//   Channel  Handshake          Payload
//   input    in_push / in_full  in_byte
//   result   out_pop / out_empty out_byte, out_is_error, out_error_code, out_last
//
// Each input byte yields at most one command from the parser.
// A text or error command gives one result; a timestamp command gives 25
// results, paced by the emitter's output register.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A full command queue raises in_full; a result not popped holds the emitter.
`timescale 1ns / 1ps
`default_nettype none
module access_log_to_tsv_converter #(
  parameter int MAX_LINE = altc_pkg::MAX_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic            out_is_error,
  output logic [1:0]      out_error_code,
  output logic            out_last
);
  import altc_pkg::*;

  // Commands from the parser and the queue's view of itself.
  cmd_t     f_cmd, q_cmd;
  logic     f_push, b_pop, res_valid;
  cq_stat_t q_stat;

  // The parser sees a byte only when the request is taken.
  altc_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_push && !q_stat.full),
    .byte_in  (in_byte),
    .cmd      (f_cmd),
    .cmd_push (f_push)
  );

  altc_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_cmd),
    .pop   (b_pop),
    .dout  (q_cmd),
    .stat  (q_stat)
  );

  // The emitter holds each result in its output register until it is popped.
  altc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_avail (!q_stat.empty),
    .cmd_pop   (b_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res_byte  (out_byte),
    .res_err   (out_is_error),
    .res_code  (out_error_code),
    .res_last  (out_last)
  );

  assign in_full   = q_stat.full;
  assign out_empty = !res_valid;

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench of the access-log to TSV converter: log lines in, checked text out.
// Depends on altc_pkg and access_log_to_tsv_converter; it reads no file.
`timescale 1ns / 1ps
module testbench;
  import altc_pkg::*;

  // Parser phases of the predictor, one per position within a log line.
  typedef enum int {
    P_START, P_HOST, P_GAP_IDENT, P_IDENT, P_GAP_USER, P_USER, P_GAP_TIME,
    P_DAY, P_MON, P_YEAR, P_HOUR, P_MIN, P_SEC, P_OFF_LEAD, P_OFF_DIG,
    P_GAP_REQ, P_REQ, P_GAP_STATUS, P_STATUS, P_GAP_BYTES, P_BYTES,
    P_GAP_REF, P_REF, P_GAP_AGENT, P_AGENT, P_EOL
  } phase_t;

  typedef struct {
    logic [7:0] data;
    logic       err;
    logic [1:0] code;
    logic       fin;
  } tsv_out_t;

  // A short line limit keeps the overlong line cheap to send.
  localparam int LINE_LIMIT = 128;
  localparam int IDLE_LIMIT = 6000;
  localparam string MONTHS = "JanFebMarAprMayJunJulAugSepOctNovDec";

  // Converter model plus the queue of text bytes it still expects to see.
  class tsv_scoreboard;
    phase_t   phase;
    int       len, day, mon, year, hour, minute, sec, neg, off, dc, mchars, mbad, halted;
    tsv_out_t pending[$];
    tsv_out_t cur[$];
    int       mismatches;

    function void reset_state();
      phase = P_START;
      len = 0; day = 0; mon = 0; year = 0; hour = 0; minute = 0; sec = 0;
      neg = 0; off = 0; dc = 0; mchars = 0; mbad = 0; halted = 0;
    endfunction

    function void put(int b, int e, logic [1:0] c);
      tsv_out_t r;
      r.data = b[7:0]; r.err = e[0]; r.code = c; r.fin = 1'b0;
      cur.push_back(r);
    endfunction

    function void emit(int b);
      put(b, 0, ERR_LAYOUT);
    endfunction

    function void fail(logic [1:0] c);
      put(0, 1, c);
      halted = 1;
    endfunction

    function bit blank(int b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
    endfunction

    function bit digit(int b);
      return b >= "0" && b <= "9";
    endfunction

    function void emit_num(int v, int n);
      int dv;
      dv = 1;
      for (int i = 1; i < n; i++) dv *= 10;
      for (int i = 0; i < n; i++) begin
        emit("0" + (v / dv) % 10);
        dv /= 10;
      end
    endfunction

    function void plain(int b, phase_t gap);
      if (b == 8'h0A || b == 0) fail(ERR_LAYOUT);
      else if (blank(b)) begin emit(8'h09); phase = gap; end
      else emit(b);
    endfunction

    function void to_plain(int b, phase_t fld);
      if (b == 8'h0A || b == 0) fail(ERR_LAYOUT);
      else if (!blank(b)) begin emit(b); phase = fld; end
    endfunction

    function void to_mark(int b, phase_t nxt);
      if (b == "\"") phase = nxt;
      else if (!blank(b)) fail(ERR_LAYOUT);
    endfunction

    function void quoted(int b, phase_t nxt, bit tab);
      if (b == "\"") begin
        if (tab) emit(8'h09);
        phase = nxt;
      end else if (b == 8'h0A || b == 0) fail(ERR_LAYOUT);
      else emit(b);
    endfunction

    // Numeric timestamp part; the value is returned through v.
    function void num(int b, inout int v, input int mind, input int maxd,
                      input int term, input phase_t nxt);
      if (digit(b) && dc < maxd) begin
        v = v * 10 + (b - "0");
        dc++;
      end else if (b == term && dc >= mind) begin
        dc = 0;
        phase = nxt;
      end else fail(ERR_DATE);
    endfunction

    function void month(int b);
      if (dc == 0 && blank(b)) return;
      if (dc < 3 && b != 0 && b != 8'h0A && !blank(b)) begin
        if (dc == 0) mchars = b << 8;
        else if (dc == 1) mchars |= b;
        else begin
          mbad = 1;
          mon = 0;
          for (int i = 0; i < 12; i++)
            if (MONTHS[3*i] == mchars[15:8] && MONTHS[3*i+1] == mchars[7:0] &&
                MONTHS[3*i+2] == b) begin
              mbad = 0;
              mon = i;
            end
        end
        dc++;
      end else if (dc == 3 && b == "/") begin
        dc = 0;
        phase = P_YEAR;
      end else fail(ERR_DATE);
    endfunction

    function void off_lead(int b);
      if (blank(b)) return;
      if (b == "+" || b == "-") begin
        neg = (b == "-");
        phase = P_OFF_DIG;
      end else if (digit(b)) begin
        off = b - "0";
        dc = 1;
        phase = P_OFF_DIG;
      end else fail(ERR_DATE);
    endfunction

    function void off_digit(int b);
      if (digit(b)) begin
        if (dc < 4) begin
          off = off * 10 + (b - "0");
          dc++;
        end else fail(ERR_DATE);
      end else if (dc == 0) fail(ERR_DATE);
      else if (mbad) fail(ERR_MONTH);
      else if (b == "]") begin
        emit_num(year, 4); emit("-");
        emit_num(mon + 1, 2); emit("-");
        emit_num(day, 2); emit("T");
        emit_num(hour, 2); emit(":");
        emit_num(minute, 2); emit(":");
        emit_num(sec, 2);
        emit((neg && off != 0) ? "-" : "+");
        emit_num(off, 4);
        emit(8'h09);
        dc = 0;
        phase = P_GAP_REQ;
      end else fail(ERR_LAYOUT);
    endfunction

    function void parse(int b);
      case (phase)
        P_START: begin
          if (b == 8'h0A) emit(8'h0A);
          else if (b == 0) fail(ERR_LAYOUT);
          else if (blank(b)) begin emit(8'h09); phase = P_GAP_IDENT; end
          else begin emit(b); phase = P_HOST; end
        end
        P_HOST:       plain(b, P_GAP_IDENT);
        P_GAP_IDENT:  to_plain(b, P_IDENT);
        P_IDENT:      plain(b, P_GAP_USER);
        P_GAP_USER:   to_plain(b, P_USER);
        P_USER:       plain(b, P_GAP_TIME);
        P_GAP_TIME: begin
          if (b == "[") begin
            day = 0; mon = 0; year = 0; hour = 0; minute = 0; sec = 0;
            neg = 0; off = 0; dc = 0; mchars = 0; mbad = 0;
            phase = P_DAY;
          end else if (!blank(b)) fail(ERR_LAYOUT);
        end
        P_DAY:        num(b, day, 1, 2, "/", P_MON);
        P_MON:        month(b);
        P_YEAR:       num(b, year, 4, 4, ":", P_HOUR);
        P_HOUR:       num(b, hour, 1, 2, ":", P_MIN);
        P_MIN:        num(b, minute, 1, 2, ":", P_SEC);
        P_SEC: begin
          if (digit(b) && dc < 2) begin
            sec = sec * 10 + (b - "0");
            dc++;
          end else if (dc == 0) fail(ERR_DATE);
          else begin
            dc = 0;
            phase = P_OFF_LEAD;
            off_lead(b);
          end
        end
        P_OFF_LEAD:   off_lead(b);
        P_OFF_DIG:    off_digit(b);
        P_GAP_REQ:    to_mark(b, P_REQ);
        P_REQ:        quoted(b, P_GAP_STATUS, 1'b1);
        P_GAP_STATUS: to_plain(b, P_STATUS);
        P_STATUS:     plain(b, P_GAP_BYTES);
        P_GAP_BYTES:  to_plain(b, P_BYTES);
        P_BYTES:      plain(b, P_GAP_REF);
        P_GAP_REF:    to_mark(b, P_REF);
        P_REF:        quoted(b, P_GAP_AGENT, 1'b1);
        P_GAP_AGENT:  to_mark(b, P_AGENT);
        P_AGENT:      quoted(b, P_EOL, 1'b0);
        P_EOL: begin
          if (b == 8'h0A) begin emit(8'h0A); phase = P_START; end
          else fail(ERR_LAYOUT);
        end
        default: fail(ERR_LAYOUT);
      endcase
    endfunction

    // Called for every byte the block has accepted.
    function void note_byte(logic [7:0] b);
      cur.delete();
      if (halted) return;
      if (b != 8'h0A && len + 1 >= LINE_LIMIT - 1) fail(ERR_LONG);
      else begin
        len++;
        parse(b);
        if (b == 8'h0A) len = 0;
      end
      if (cur.size() > 0) cur[cur.size()-1].fin = 1'b1;
      foreach (cur[i]) pending.push_back(cur[i]);
    endfunction

    function void report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endfunction

    function void check_text(logic [7:0] d, logic e, logic [1:0] c, logic f);
      tsv_out_t x;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", d));
        return;
      end
      x = pending.pop_front();
      if (d !== x.data) report_mismatch($sformatf("byte %02h, want %02h", d, x.data));
      if (e !== x.err) report_mismatch($sformatf("is_error %b, want %b", e, x.err));
      if (c !== x.code) report_mismatch($sformatf("error_code %0d, want %0d", c, x.code));
      if (f !== x.fin) report_mismatch($sformatf("last %b, want %b", f, x.fin));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_is_error;
  logic [1:0] out_error_code;
  logic       out_last;

  tsv_scoreboard sb;
  int  idle_cycles;
  int  popped;
  bit  quiet_sender;
  logic [7:0] line[$];

  access_log_to_tsv_converter #(.MAX_LINE(LINE_LIMIT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_byte(in_byte),
    .out_empty(out_empty), .out_pop(out_pop), .out_byte(out_byte),
    .out_is_error(out_is_error), .out_error_code(out_error_code), .out_last(out_last)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte to the block and waits until it has been taken.
  task automatic send_byte(input logic [7:0] b);
    int g;
    g = quiet_sender ? 0 : pick_gap();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    sb.note_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line();
    quiet_sender = ($urandom_range(0, 3) == 0);
    foreach (line[i]) send_byte(line[i]);
    line.delete();
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0B;
      3: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic bit is_sep(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D ||
           b == 8'h00 || b == 8'h0A;
  endfunction

  // Field builders append to the line under construction.
  task automatic add_token(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = $urandom_range(1, 255); while (is_sep(b));
      line.push_back(b);
    end
  endtask

  task automatic add_quoted(input int n);
    logic [7:0] b;
    line.push_back("\"");
    for (int i = 0; i < n; i++) begin
      do b = $urandom_range(1, 255); while (b == 8'h0A || b == "\"");
      line.push_back(b);
    end
    line.push_back("\"");
  endtask

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) line.push_back(any_blank());
  endtask

  task automatic add_digits(input int n);
    repeat (n) line.push_back("0" + $urandom_range(0, 9));
  endtask

  // A well-formed combined-log line with random content.
  task automatic build_line();
    int m;
    if ($urandom_range(0, 7) == 0) begin
      line.push_back(any_blank());
    end else begin
      add_token($urandom_range(1, 4));
      add_blanks(1, 2);
    end
    add_token($urandom_range(1, 2)); add_blanks(1, 2);
    add_token($urandom_range(1, 2)); add_blanks(1, 2);
    line.push_back("[");
    add_digits($urandom_range(1, 2)); line.push_back("/");
    add_blanks(0, 1);
    m = $urandom_range(0, 11);
    for (int i = 0; i < 3; i++) line.push_back(MONTHS[3*m+i]);
    line.push_back("/"); add_digits(4);
    line.push_back(":"); add_digits($urandom_range(1, 2));
    line.push_back(":"); add_digits($urandom_range(1, 2));
    line.push_back(":"); add_digits($urandom_range(1, 2));
    case ($urandom_range(0, 2))
      0: begin add_blanks(1, 2); end
      1: begin add_blanks(0, 1); line.push_back("+"); end
      default: begin add_blanks(0, 1); line.push_back("-"); end
    endcase
    add_digits($urandom_range(1, 4));
    line.push_back("]");
    add_blanks(0, 1); add_quoted($urandom_range(0, 6));
    add_blanks(1, 2); add_token($urandom_range(1, 3));
    add_blanks(1, 2); add_token($urandom_range(1, 3));
    add_blanks(1, 2); add_quoted($urandom_range(0, 4));
    add_blanks(0, 1); add_quoted($urandom_range(0, 6));
    line.push_back(8'h0A);
  endtask

  // Result side: random pops, and one long hold-off once the flow is under way
  // so that the command queue fills and the block pushes back on its input.
  initial begin
    int gap;
    bit held;
    gap = 0;
    held = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        sb.check_text(out_byte, out_is_error, out_error_code, out_last);
        popped++;
        if (!held && popped == 60) begin
          held = 1;
          gap = 400;
        end else begin
          gap = pick_gap();
        end
      end
      if (gap > 0) begin
        gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: a long run of cycles with neither request nor result moving.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.reset_state();
    sb.mismatches = 0;
    popped = 0;
    idle_cycles = 0;
    quiet_sender = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_byte = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: an empty line, a plain line, a line with an empty host whose
    // seconds run straight into the offset digits, a negative zero offset and a negative one.
    send_text("\n");
    send_text("1.2 - u [01/Jan/2000:00:00:00 +0000] \"GET /\" 200 5 \"-\" \"ua\"\n");
    send_text(" x y [99/ Dec/9999:99:99:5912]\"\"\t1 2\"\"\"\"\n");
    send_text("h i u [1/Feb/0000:1:2:3 -0000] \"\" 0 0 \"\" \"\"\n");
    send_text("h i u [7/Jul/1900:4:5:6 -9999] \"q\" 3 4 \"r\" \"s\"\n");

    // Random well-formed lines, with an empty line now and then.
    begin : rand_lines
      int sent;
      sent = 0;
      while (sent < 60) begin
        if ($urandom_range(0, 9) == 0) line.push_back(8'h0A);
        else build_line();
        sent += line.size();
        send_line();
      end
    end

    // The block stops for good at the first error, so one broken line ends
    // the stimulus; the bytes after it must produce nothing.
    case ($urandom_range(0, 3))
      0: send_text("host\n");
      1: repeat (LINE_LIMIT) send_byte("a");
      2: send_text("h i u [1/Jan/20x");
      default: send_text("h i u [1/Foo/2000:1:2:3 +1]");
    endcase
    send_text("ab \"c\"\n");
    in_push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
